// File: hw/rtl/cqmd_pkg.sv
// shared types and constants for the circular queue with multi-item dequeue
`default_nettype none

package cqmd_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int OPCODE_W    = 2;
    localparam int VALUE_W     = 8;
    localparam int COUNT_W     = 5;
    localparam int KIND_W      = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_LIST    = 2'd2
    } opcode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_EMPTY    = 3'd2,
        KIND_DEQUEUED = 3'd3,
        KIND_PENDING  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic  enq;
        logic  rsp_single;
        kind_t rsp_kind;
        logic  run_start;
        logic  fetch;
        logic  emit;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    full;
        logic    empty;
        logic    take_zero;
        logic    out_free;
        logic    last_item;
    } status_t;

endpackage

`default_nettype wire

// File: hw/rtl/cqmd_ctrl.sv
// controller state machine sequencing enqueue, dequeue runs and list runs
`default_nettype none

module cqmd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire cqmd_pkg::status_t status,
    output cqmd_pkg::cmd_t       cmd
);

    cqmd_pkg::state_t state_reg;
    cqmd_pkg::state_t state_next;
    logic             accept;

    assign in_ready = (state_reg == cqmd_pkg::ST_IDLE) && status.out_free;
    assign accept   = in_ready && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cqmd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cqmd_pkg::ST_IDLE:
            begin
                if (accept && !status.empty)
                begin
                    if ((status.op == cqmd_pkg::OP_DEQUEUE && !status.take_zero) ||
                        status.op == cqmd_pkg::OP_LIST)
                    begin
                        state_next = cqmd_pkg::ST_FETCH;
                    end
                end
            end
            cqmd_pkg::ST_FETCH:
            begin
                state_next = cqmd_pkg::ST_SEND;
            end
            cqmd_pkg::ST_SEND:
            begin
                if (status.out_free && status.last_item)
                begin
                    state_next = cqmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cqmd_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            cqmd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (status.op)
                        cqmd_pkg::OP_ENQUEUE:
                        begin
                            cmd.rsp_single = 1'b1;
                            if (status.full)
                            begin
                                cmd.rsp_kind = cqmd_pkg::KIND_FULL;
                            end
                            else
                            begin
                                cmd.enq      = 1'b1;
                                cmd.rsp_kind = cqmd_pkg::KIND_ACCEPTED;
                            end
                        end
                        cqmd_pkg::OP_DEQUEUE, cqmd_pkg::OP_LIST:
                        begin
                            if (status.empty)
                            begin
                                cmd.rsp_single = 1'b1;
                                cmd.rsp_kind   = cqmd_pkg::KIND_EMPTY;
                            end
                            else if (status.op == cqmd_pkg::OP_LIST || !status.take_zero)
                            begin
                                cmd.run_start = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            cqmd_pkg::ST_FETCH:
            begin
                cmd.fetch = 1'b1;
            end
            cqmd_pkg::ST_SEND:
            begin
                if (status.out_free)
                begin
                    cmd.emit  = 1'b1;
                    cmd.fetch = !status.last_item;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_single_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rsp_single || cmd.run_start) |-> (state_reg == cqmd_pkg::ST_IDLE))
        else $error("transaction started outside idle");

    a_fetch_then_send: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cqmd_pkg::ST_FETCH) |=> (state_reg == cqmd_pkg::ST_SEND))
        else $error("fetch not followed by send");

    a_run_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_start |=> (state_reg == cqmd_pkg::ST_FETCH))
        else $error("run start did not enter fetch");

endmodule

`default_nettype wire

// File: hw/rtl/cqmd_dp.sv
// datapath: slot memory, head/tail pointers, occupancy, run counter and output register
`default_nettype none

module cqmd_dp #(
    parameter int DEPTH = cqmd_pkg::DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [cqmd_pkg::IN_TDATA_W-1:0]    in_data,
    input  wire logic [cqmd_pkg::OPCODE_W-1:0]      in_user,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic [cqmd_pkg::OUT_TDATA_W-1:0]        out_data,
    output logic                                    out_last,
    output logic [cqmd_pkg::KIND_W-1:0]             out_user,
    input  wire cqmd_pkg::cmd_t                     cmd,
    output cqmd_pkg::status_t                       status
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (OCC_W > cqmd_pkg::COUNT_W) ? OCC_W : cqmd_pkg::COUNT_W;

    logic [cqmd_pkg::VALUE_W-1:0] slot_mem [DEPTH];
    logic [cqmd_pkg::VALUE_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] remain_reg;
    logic             op_deq_reg;

    logic                          out_valid_reg;
    cqmd_pkg::kind_t               out_kind_reg;
    logic [cqmd_pkg::VALUE_W-1:0]  out_value_reg;
    logic                          out_last_reg;

    logic [cqmd_pkg::VALUE_W-1:0] item_value;
    logic [cqmd_pkg::COUNT_W-1:0] take_count;
    logic [CMP_W-1:0]             count_ext;
    logic [CMP_W-1:0]             occ_ext;
    logic [OCC_W-1:0]             take;
    logic                         out_free;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] r;
        begin
            if (x == IDX_W'(DEPTH - 1))
            begin
                r = '0;
            end
            else
            begin
                r = x + 1'b1;
            end
            return r;
        end
    endfunction

    assign item_value = in_data[cqmd_pkg::VALUE_W-1:0];
    assign take_count = in_data[cqmd_pkg::VALUE_W +: cqmd_pkg::COUNT_W];
    assign count_ext  = CMP_W'(take_count);
    assign occ_ext    = CMP_W'(occ_reg);
    assign take       = (count_ext < occ_ext) ? OCC_W'(count_ext) : occ_reg;
    assign out_free   = !out_valid_reg || out_ready;

    assign status.op        = cqmd_pkg::opcode_t'(in_user);
    assign status.full      = (occ_reg == OCC_W'(DEPTH));
    assign status.empty     = (occ_reg == '0);
    assign status.take_zero = (take_count == '0);
    assign status.out_free  = out_free;
    assign status.last_item = (remain_reg == OCC_W'(1));

    // slot memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.enq)
        begin
            slot_mem[tail_reg] <= item_value;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= slot_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            rd_ptr_reg    <= '0;
            occ_reg       <= '0;
            remain_reg    <= '0;
            op_deq_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.enq)
            begin
                tail_reg <= next_idx(tail_reg);
                occ_reg  <= occ_reg + 1'b1;
            end
            if (cmd.run_start)
            begin
                op_deq_reg <= (status.op == cqmd_pkg::OP_DEQUEUE);
                remain_reg <= (status.op == cqmd_pkg::OP_DEQUEUE) ? take : occ_reg;
                rd_ptr_reg <= head_reg;
            end
            if (cmd.fetch)
            begin
                rd_ptr_reg <= next_idx(rd_ptr_reg);
            end
            if (cmd.emit)
            begin
                remain_reg <= remain_reg - 1'b1;
                if (op_deq_reg)
                begin
                    head_reg <= next_idx(head_reg);
                    occ_reg  <= occ_reg - 1'b1;
                end
            end
            if (cmd.rsp_single || cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.rsp_single)
        begin
            out_kind_reg  <= cmd.rsp_kind;
            out_value_reg <= '0;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.emit)
        begin
            out_kind_reg  <= op_deq_reg ? cqmd_pkg::KIND_DEQUEUED : cqmd_pkg::KIND_PENDING;
            out_value_reg <= rd_data_reg;
            out_last_reg  <= (remain_reg == OCC_W'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = cqmd_pkg::OUT_TDATA_W'(out_value_reg);
    assign out_last  = out_last_reg;
    assign out_user  = out_kind_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_emit_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (remain_reg != '0))
        else $error("emit with nothing remaining");

    a_enq_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.enq |-> !status.full)
        else $error("enqueue into full queue");

    a_deq_drops_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && op_deq_reg) |=> (occ_reg == $past(occ_reg) - 1'b1))
        else $error("dequeue did not lower occupancy");

    a_no_load_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rsp_single || cmd.emit) |-> out_free)
        else $error("output register overwritten");

endmodule

`default_nettype wire

// File: hw/rtl/circular_queue_multi_dequeue.sv
// circular queue of 8-bit items with enqueue, multi-item dequeue and list
// usage:
//   input transaction on s_axis: tuser carries the opcode (enqueue, dequeue,
//   list), tdata carries the item value and the dequeue count.
//   each input gives zero or more output transactions on m_axis: tuser is
//   the result kind, tdata the item value, tlast marks the final result.
//   enqueue and empty/full answers are one result, shown the cycle after
//   the input transaction; one such input can be taken every cycle while
//   m_axis_tready is high. a dequeue or list run of n items (n up to DEPTH)
//   shows its first item after the FETCH state, the registered slot memory
//   read and the output register, then one item per cycle while m_axis_tready
//   is high; it holds the input until its last item is loaded. the FETCH state
//   comes from the single registered read port of the slot memory.
//   a dequeue with count zero on a non-empty queue and opcode 3 give no result.
//   when m_axis_tready is low the result holds in the output register and
//   both the run and the input side wait.
//   reset clears pointers and occupancy (queue empty); slot contents are
//   not cleared and need no clearing pass.
`default_nettype none

module circular_queue_multi_dequeue #(
    parameter int DEPTH = cqmd_pkg::DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // item_value [7:0], take_count [12:8], zero [15:13]
    input  wire logic [cqmd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // opcode [1:0]
    input  wire logic [cqmd_pkg::OPCODE_W-1:0]   s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // value_out [7:0]
    output logic [cqmd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast,
    // kind [2:0]
    output logic [cqmd_pkg::KIND_W-1:0]          m_axis_tuser
);

    cqmd_pkg::cmd_t    cmd;
    cqmd_pkg::status_t status;

    cqmd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cqmd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_user  (m_axis_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// File: tb/circular_queue_multi_dequeue_test.sv
// self-checking testbench for the circular queue with enqueue, multi-item dequeue and list
`default_nettype none

module circular_queue_multi_dequeue_test;

    localparam int DEPTH = cqmd_pkg::DEPTH_DEF;
    localparam logic [cqmd_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 60;
    localparam int RANDOM_ITEMS = 200;
    localparam int STEADY_ITEMS = 40;
    localparam int MAX_PRINTED = 100;

    typedef struct packed {
        cqmd_pkg::kind_t              kind;
        logic [cqmd_pkg::VALUE_W-1:0] value;
        logic                         last;
    } result_t;

    class queue_scoreboard;
        logic [cqmd_pkg::VALUE_W-1:0] slots [DEPTH];
        int head;
        int tail;
        int occupancy;
        result_t pending [$];
        int errors;
        int items_taken;
        int results_checked;
        int full_count;
        int empty_count;
        int longest_run;

        function new();
            head = 0;
            tail = 0;
            occupancy = 0;
            errors = 0;
            items_taken = 0;
            results_checked = 0;
            full_count = 0;
            empty_count = 0;
            longest_run = 0;
        endfunction

        function void add_result(cqmd_pkg::kind_t kind, logic [cqmd_pkg::VALUE_W-1:0] value,
                                 logic last);
            result_t r;
            r.kind = kind;
            r.value = value;
            r.last = last;
            pending.push_back(r);
        endfunction

        // predicts the results of one accepted input transaction
        function void note_input(logic [cqmd_pkg::OPCODE_W-1:0] op,
                                 logic [cqmd_pkg::VALUE_W-1:0] value,
                                 logic [cqmd_pkg::COUNT_W-1:0] count);
            int take;
            int slot;
            int n;
            items_taken++;
            case (op)
                cqmd_pkg::OP_ENQUEUE:
                begin
                    if (occupancy >= DEPTH)
                    begin
                        add_result(cqmd_pkg::KIND_FULL, '0, 1'b1);
                        full_count++;
                    end
                    else
                    begin
                        slots[tail] = value;
                        tail = (tail + 1) % DEPTH;
                        occupancy++;
                        add_result(cqmd_pkg::KIND_ACCEPTED, '0, 1'b1);
                    end
                end
                cqmd_pkg::OP_DEQUEUE:
                begin
                    if (occupancy == 0)
                    begin
                        add_result(cqmd_pkg::KIND_EMPTY, '0, 1'b1);
                        empty_count++;
                    end
                    else
                    begin
                        take = (int'(count) < occupancy) ? int'(count) : occupancy;
                        for (n = 0; n < take; n++)
                        begin
                            add_result(cqmd_pkg::KIND_DEQUEUED, slots[head], n + 1 == take);
                            head = (head + 1) % DEPTH;
                            occupancy--;
                        end
                        if (take > longest_run)
                            longest_run = take;
                    end
                end
                cqmd_pkg::OP_LIST:
                begin
                    if (occupancy == 0)
                    begin
                        add_result(cqmd_pkg::KIND_EMPTY, '0, 1'b1);
                        empty_count++;
                    end
                    else
                    begin
                        slot = head;
                        for (n = 0; n < occupancy; n++)
                        begin
                            add_result(cqmd_pkg::KIND_PENDING, slots[slot],
                                       n + 1 == occupancy);
                            slot = (slot + 1) % DEPTH;
                        end
                        if (occupancy > longest_run)
                            longest_run = occupancy;
                    end
                end
                default:
                    ;
            endcase
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTED)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [cqmd_pkg::KIND_W-1:0] kind,
                          logic [cqmd_pkg::VALUE_W-1:0] value, logic last);
            result_t want;
            results_checked++;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d value %02h last %0b",
                                          kind, value, last));
                return;
            end
            want = pending.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %s", kind, want.kind.name()));
            if (value !== want.value)
                report_mismatch($sformatf("value %02h, expected %02h", value, want.value));
            if (last !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
        endtask
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [cqmd_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic [cqmd_pkg::OPCODE_W-1:0]    s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [cqmd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;
    logic [cqmd_pkg::KIND_W-1:0]      m_axis_tuser;

    queue_scoreboard tracker = new();
    bit steady;
    bit hold_request;
    int fill_goal;

    circular_queue_multi_dequeue #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("timeout with %0d results outstanding", tracker.pending.size());
        $display("circular_queue_multi_dequeue_test: FAIL");
        $finish;
    end

    // result side: random stalls and one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                m_axis_tready = 1'b1;
            end
            else if (!steady && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    always @(posedge clk)
        if (m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);

    task automatic send_item(input logic [cqmd_pkg::OPCODE_W-1:0] op,
                             input logic [cqmd_pkg::VALUE_W-1:0] value,
                             input logic [cqmd_pkg::COUNT_W-1:0] count);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {3'b000, count, value};
        do @(posedge clk); while (!s_axis_tready);
        tracker.note_input(op, value, count);
        @(negedge clk);
        if (!steady && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    task automatic random_item();
        int r;
        int occ;
        logic [cqmd_pkg::VALUE_W-1:0] value;
        logic [cqmd_pkg::COUNT_W-1:0] count;
        occ = tracker.occupancy;
        r = $urandom_range(0, 99);
        value = cqmd_pkg::VALUE_W'($urandom_range(0, 255));
        count = cqmd_pkg::COUNT_W'($urandom_range(0, 16));
        if (r < 4)
            send_item(OP_UNUSED, value, count);
        else if (r < 16)
            send_item(cqmd_pkg::OP_LIST, value, count);
        else if ((occ < fill_goal && r < 80) || (occ >= fill_goal && r < 40))
            send_item(cqmd_pkg::OP_ENQUEUE, value, count);
        else
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                count = '0;
            else if (r < 3 || occ == 0)
                count = cqmd_pkg::COUNT_W'($urandom_range(0, 16));
            else
                count = cqmd_pkg::COUNT_W'($urandom_range(1, occ));
            send_item(cqmd_pkg::OP_DEQUEUE, value, count);
        end
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = cqmd_pkg::OP_ENQUEUE;
        steady = 1'b0;
        hold_request = 1'b0;
        fill_goal = 8;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty queue answers, ignored opcode
        send_item(cqmd_pkg::OP_DEQUEUE, 8'hFF, 5'd5);
        send_item(cqmd_pkg::OP_LIST, 8'h00, 5'd16);
        send_item(OP_UNUSED, 8'hFF, 5'd31);
        // fill to capacity, then one rejected
        send_item(cqmd_pkg::OP_ENQUEUE, 8'h00, 5'd0);
        send_item(cqmd_pkg::OP_ENQUEUE, 8'hFF, 5'd31);
        for (i = 2; i < DEPTH; i++)
            send_item(cqmd_pkg::OP_ENQUEUE, cqmd_pkg::VALUE_W'($urandom_range(0, 255)),
                      cqmd_pkg::COUNT_W'($urandom_range(0, 16)));
        send_item(cqmd_pkg::OP_ENQUEUE, 8'hA5, 5'd0);
        send_item(cqmd_pkg::OP_LIST, 8'h5A, 5'd0);
        // zero count on a full queue gives nothing
        send_item(cqmd_pkg::OP_DEQUEUE, 8'h00, 5'd0);
        send_item(OP_UNUSED, 8'h00, 5'd0);
        send_item(cqmd_pkg::OP_DEQUEUE, 8'h3C, 5'd3);
        // count above occupancy drains the rest
        send_item(cqmd_pkg::OP_DEQUEUE, 8'hC3, 5'd16);

        // long result-side hold-off while inputs keep coming
        hold_request = 1'b1;
        for (i = 0; i < 12; i++)
            send_item(cqmd_pkg::OP_ENQUEUE, cqmd_pkg::VALUE_W'($urandom_range(0, 255)),
                      cqmd_pkg::COUNT_W'($urandom_range(0, 16)));
        send_item(cqmd_pkg::OP_LIST, 8'h00, 5'd0);
        send_item(cqmd_pkg::OP_DEQUEUE, 8'h00, 5'd16);
        send_item(cqmd_pkg::OP_LIST, 8'h00, 5'd0);

        for (i = 0; i < RANDOM_ITEMS + STEADY_ITEMS; i++)
        begin
            if (i % 25 == 0)
                fill_goal = ($urandom_range(0, 3) == 0) ? DEPTH + 1 : $urandom_range(0, DEPTH);
            if (i == RANDOM_ITEMS)
                steady = 1'b1;
            random_item();
        end
        s_axis_tvalid = 1'b0;

        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (3 * DEPTH) @(posedge clk);

        $display("covered %0d input transactions and %0d result transactions",
                 tracker.items_taken, tracker.results_checked);
        $display("full rejections %0d, empty answers %0d, longest run %0d items",
                 tracker.full_count, tracker.empty_count, tracker.longest_run);
        if (tracker.errors == 0)
            $display("circular_queue_multi_dequeue_test: PASS");
        else
            $display("circular_queue_multi_dequeue_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
